>>> rtl/core/fcm_pkg.sv
`timescale 1ns / 1ps

package fcm_pkg;

	localparam int OP_W  = 3;
	localparam int VAL_W = 16;
	localparam int CNT_W = 14;
	localparam int ST_W  = 2;

	localparam logic [VAL_W-1:0] END_MARK = 16'hFFFF;
	localparam logic [CNT_W-1:0] DBC_RESET = 14'd8192;
	localparam int CNT_CAP = (1 << CNT_W) - 1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_ALLOC  = 3'd2,
		OP_APPEND = 3'd3,
		OP_SEEK   = 3'd4,
		OP_FREE   = 3'd5,
		OP_COUNT  = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EARLY = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_VAL,
		WR_LINK,
		WR_MARK,
		WR_ZERO
	} wr_sel_t;

	typedef enum logic [1:0] {
		RES_KEEP,
		RES_CUR,
		RES_PROBE,
		RES_FR
	} res_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		logic     clear;
		logic     probe_rd;
		logic     rd_walk;
		logic     rd_scan;
		logic     scan_cnt;
		logic     adv_cur;
		logic     dec_hops;
		logic     inc_tally;
		wr_sel_t  wr_sel;
		res_sel_t res_sel;
		logic     st_en;
		st_t      st;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic clear_last;
		logic p_end;
		logic p_zero;
		logic p_oor;
		logic tally_lim;
		logic hops_zero;
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/core/fcm_req_if.sv
`timescale 1ns / 1ps

interface fcm_req_if;
	logic                        valid;
	logic                        ready;
	logic [fcm_pkg::OP_W-1:0]    opcode;
	logic [fcm_pkg::VAL_W-1:0]   block;
	logic [fcm_pkg::VAL_W-1:0]   entry_value;
	logic [fcm_pkg::VAL_W-1:0]   hops;

	modport source (output valid, output opcode, output block, output entry_value,
		output hops, input ready);
	modport sink (input valid, input opcode, input block, input entry_value,
		input hops, output ready);
endinterface

>>> rtl/core/fcm_rsp_if.sv
`timescale 1ns / 1ps

interface fcm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fcm_pkg::VAL_W-1:0]   result_block;
	logic [fcm_pkg::CNT_W-1:0]   tally;
	logic [fcm_pkg::ST_W-1:0]    status;

	modport source (output valid, output result_block, output tally, output status,
		input ready);
	modport sink (input valid, input result_block, input tally, input status,
		output ready);
endinterface

>>> rtl/core/fcm_cfg.sv
`timescale 1ns / 1ps

module fcm_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [fcm_pkg::CNT_W-1:0] dbc
);
	import fcm_pkg::*;

	logic [CNT_W-1:0] dbc_q;
	logic             sel_dbc;

	assign sel_dbc = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign dbc     = dbc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbc_q <= DBC_RESET;
		end else if (psel && penable && pwrite && pready && sel_dbc) begin
			dbc_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_dbc) begin
			prdata = {{(32-CNT_W){1'b0}}, dbc_q};
		end
	end

endmodule

>>> rtl/core/fcm_datapath.sv
`timescale 1ns / 1ps

module fcm_datapath #(
	parameter int MAX_ENTRIES = 8192
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fcm_pkg::dp_cmd_t          cmd,
	output fcm_pkg::dp_sts_t          sts,
	input  logic [fcm_pkg::CNT_W-1:0] dbc,
	fcm_req_if.sink                   request,
	fcm_rsp_if.source                 response
);
	import fcm_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int NCAP = (MAX_ENTRIES > CNT_CAP) ? CNT_CAP : MAX_ENTRIES;

	logic [VAL_W-1:0] mem_q [MAX_ENTRIES];
	logic [VAL_W-1:0] rdata_q;

	op_t              op_q;
	logic [VAL_W-1:0] cur_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] hops_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pidx_q;
	logic             pend_q;
	logic [CNT_W-1:0] fr_q;
	logic [CNT_W-1:0] tally_q;
	logic [VAL_W-1:0] res_q;
	st_t              st_q;
	logic [AW-1:0]    clr_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_res_q;
	logic [CNT_W-1:0] out_tally_q;
	st_t              out_st_q;

	logic [CNT_W-1:0] n_eff;
	logic [VAL_W-1:0] probe;
	logic [VAL_W-1:0] hp;
	logic [CNT_W:0]   tp;
	logic             idx_lt_n;
	logic             we;
	logic [AW-1:0]    wa;
	logic [VAL_W-1:0] wd;
	logic             re;
	logic [AW-1:0]    ra;

	function automatic logic [AW-1:0] to_addr(input logic [VAL_W-1:0] v);
		return v[AW-1:0];
	endfunction

	assign n_eff    = (dbc > CNT_W'(NCAP)) ? CNT_W'(NCAP) : dbc;
	assign probe    = cmd.probe_rd ? rdata_q : cur_q;
	assign hp       = cmd.probe_rd ? (hops_q - 16'd1) : hops_q;
	assign tp       = cmd.probe_rd ? ({1'b0, tally_q} + 15'd1) : {1'b0, tally_q};
	assign idx_lt_n = (idx_q < n_q);

	always_comb begin
		sts.in_valid   = request.valid;
		sts.op         = op_q;
		sts.clear_last = (clr_q == AW'(MAX_ENTRIES - 1));
		sts.p_end      = (probe == END_MARK);
		sts.p_zero     = (probe == '0);
		sts.p_oor      = (probe >= {{(VAL_W-CNT_W){1'b0}}, n_q});
		sts.tally_lim  = (tp >= {1'b0, n_q});
		sts.hops_zero  = (hp == '0);
		sts.scan_hit   = pend_q && (rdata_q == '0);
		sts.scan_done  = !pend_q && !idx_lt_n;
		sts.out_free   = !out_valid_q || response.ready;
	end

	always_comb begin
		we = 1'b1;
		wa = to_addr(cur_q);
		wd = '0;
		case (cmd.wr_sel)
			WR_VAL: begin
				wd = val_q;
			end
			WR_LINK: begin
				wd = {{(VAL_W-CNT_W){1'b0}}, fr_q};
			end
			WR_MARK: begin
				wa = to_addr({{(VAL_W-CNT_W){1'b0}}, fr_q});
				wd = END_MARK;
			end
			WR_ZERO: begin
				wd = '0;
			end
			default: begin
				we = cmd.clear;
				wa = clr_q;
				wd = (clr_q == '0) ? END_MARK : '0;
			end
		endcase
	end

	assign re = cmd.rd_walk || (cmd.rd_scan && idx_lt_n);
	assign ra = cmd.rd_scan ? to_addr({{(VAL_W-CNT_W){1'b0}}, idx_q}) : to_addr(probe);

	// write-first on a same-address read, needed for a chain linking to itself
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rdata_q <= (we && (wa == ra)) ? wd : mem_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				pend_q <= 1'b0;
			end else if (cmd.rd_scan) begin
				pend_q <= idx_lt_n;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(request.opcode);
			cur_q   <= request.block;
			val_q   <= request.entry_value;
			hops_q  <= request.hops;
			n_q     <= n_eff;
			idx_q   <= CNT_W'(1);
			tally_q <= '0;
			res_q   <= '0;
			st_q    <= ST_OK;
		end else begin
			if (cmd.rd_scan) begin
				if (pend_q && (rdata_q == '0)) begin
					fr_q <= pidx_q;
					if (cmd.scan_cnt) begin
						tally_q <= tally_q + 1'b1;
					end
				end
				if (idx_lt_n) begin
					pidx_q <= idx_q;
					idx_q  <= idx_q + 1'b1;
				end
			end
			if (cmd.inc_tally) begin
				tally_q <= tp[CNT_W-1:0];
			end
			if (cmd.adv_cur) begin
				cur_q <= probe;
			end
			if (cmd.dec_hops) begin
				hops_q <= hp;
			end
			case (cmd.res_sel)
				RES_CUR:   res_q <= cur_q;
				RES_PROBE: res_q <= probe;
				RES_FR:    res_q <= {{(VAL_W-CNT_W){1'b0}}, fr_q};
				default:   res_q <= res_q;
			endcase
			if (cmd.st_en) begin
				st_q <= cmd.st;
			end
		end
		if (cmd.load_out) begin
			out_res_q   <= res_q;
			out_tally_q <= tally_q;
			out_st_q    <= st_q;
		end
	end

	assign request.ready         = cmd.in_ready;
	assign response.valid        = out_valid_q;
	assign response.result_block = out_res_q;
	assign response.tally        = out_tally_q;
	assign response.status       = out_st_q;

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (pidx_q < n_q))
		else $error("scan read issued beyond table size");

	a_walk_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == WR_VAL || cmd.wr_sel == WR_LINK || cmd.wr_sel == WR_ZERO)
		|-> (cur_q < {{(VAL_W-CNT_W){1'b0}}, n_q}))
		else $error("table write outside used entries");

	a_mark_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == WR_MARK) |-> (fr_q != '0 && fr_q < n_q))
		else $error("end mark written to a bad free entry");

endmodule

>>> rtl/core/fcm_ctrl.sv
`timescale 1ns / 1ps

module fcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  fcm_pkg::dp_sts_t  sts,
	output fcm_pkg::dp_cmd_t  cmd
);
	import fcm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_WRITE,
		S_READ,
		S_READ_WAIT,
		S_CHECK,
		S_SCAN,
		S_LINK,
		S_MARK,
		S_SEEK,
		S_SEEK_WAIT,
		S_FREE,
		S_FREE_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		cmd.wr_sel  = WR_NONE;
		cmd.res_sel = RES_KEEP;
		cmd.st      = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_WRITE:  nxt = S_WRITE;
					OP_READ:   nxt = S_READ;
					OP_ALLOC:  nxt = S_SCAN;
					OP_APPEND: nxt = S_CHECK;
					OP_SEEK:   nxt = S_SEEK;
					OP_FREE:   nxt = S_FREE;
					OP_COUNT:  nxt = S_SCAN;
					default:   nxt = S_DONE;
				endcase
			end
			S_WRITE: begin
				if (sts.p_oor) begin
					cmd.st_en = 1'b1;
					cmd.st    = ST_RANGE;
				end else begin
					cmd.wr_sel  = WR_VAL;
					cmd.res_sel = RES_CUR;
				end
				nxt = S_DONE;
			end
			S_READ: begin
				if (sts.p_oor) begin
					cmd.st_en = 1'b1;
					cmd.st    = ST_RANGE;
					nxt = S_DONE;
				end else begin
					cmd.rd_walk = 1'b1;
					nxt = S_READ_WAIT;
				end
			end
			S_READ_WAIT: begin
				cmd.probe_rd = 1'b1;
				cmd.res_sel  = RES_PROBE;
				nxt = S_DONE;
			end
			S_CHECK: begin
				if (sts.p_oor) begin
					cmd.st_en = 1'b1;
					cmd.st    = ST_RANGE;
					nxt = S_DONE;
				end else begin
					nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_scan  = 1'b1;
				cmd.scan_cnt = (sts.op == OP_COUNT);
				if (sts.op != OP_COUNT && sts.scan_hit) begin
					nxt = (sts.op == OP_APPEND) ? S_LINK : S_MARK;
				end else if (sts.scan_done) begin
					if (sts.op != OP_COUNT) begin
						cmd.st_en = 1'b1;
						cmd.st    = ST_FULL;
					end
					nxt = S_DONE;
				end
			end
			S_LINK: begin
				cmd.wr_sel = WR_LINK;
				nxt = S_MARK;
			end
			S_MARK: begin
				cmd.wr_sel  = WR_MARK;
				cmd.res_sel = RES_FR;
				nxt = S_DONE;
			end
			S_SEEK: begin
				if (sts.hops_zero) begin
					cmd.res_sel = RES_PROBE;
					nxt = S_DONE;
				end else if (sts.p_oor) begin
					cmd.res_sel = RES_PROBE;
					cmd.st_en   = 1'b1;
					cmd.st      = ST_RANGE;
					nxt = S_DONE;
				end else begin
					cmd.rd_walk = 1'b1;
					nxt = S_SEEK_WAIT;
				end
			end
			S_SEEK_WAIT: begin
				cmd.probe_rd = 1'b1;
				if (sts.p_end) begin
					cmd.res_sel = RES_CUR;
					cmd.st_en   = 1'b1;
					cmd.st      = ST_EARLY;
					nxt = S_DONE;
				end else begin
					cmd.adv_cur  = 1'b1;
					cmd.dec_hops = 1'b1;
					if (sts.hops_zero) begin
						cmd.res_sel = RES_PROBE;
						nxt = S_DONE;
					end else if (sts.p_oor) begin
						cmd.res_sel = RES_PROBE;
						cmd.st_en   = 1'b1;
						cmd.st      = ST_RANGE;
						nxt = S_DONE;
					end else begin
						cmd.rd_walk = 1'b1;
					end
				end
			end
			S_FREE, S_FREE_WAIT: begin
				if (state_q == S_FREE_WAIT) begin
					cmd.probe_rd  = 1'b1;
					cmd.wr_sel    = WR_ZERO;
					cmd.inc_tally = 1'b1;
					cmd.adv_cur   = 1'b1;
				end
				if (sts.p_end) begin
					nxt = S_DONE;
				end else if (sts.p_zero || sts.p_oor) begin
					cmd.st_en = 1'b1;
					cmd.st    = ST_RANGE;
					nxt = S_DONE;
				end else if (sts.tally_lim) begin
					cmd.st_en = 1'b1;
					cmd.st    = ST_EARLY;
					nxt = S_DONE;
				end else begin
					cmd.rd_walk = 1'b1;
					nxt = S_FREE_WAIT;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.in_ready)
		else $error("second item taken while one is in progress");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over one not yet taken");

	a_sweep_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear && sts.clear_last) |=> cmd.in_ready)
		else $error("table clear did not hand over to idle");

endmodule

>>> rtl/core/fat_chain_manager.sv
`timescale 1ns / 1ps

// FAT16 chain manager. After reset the table is swept clear, one entry a cycle, before the
// first item is taken. Each item then passes through accept, decode and result load, plus
// the table accesses it needs. Write makes one table access and read one, none when out
// of range. Seek reads once per link followed, and free chain once per entry freed.
// Allocate and count free scan entries 1 to n-1 through the single read port of the
// table memory, one a cycle; allocate stops once the first free entry is read and then
// writes the end mark. Append adds a range check and a link write to that. n is
// data_block_count capped at MAX_ENTRIES and at 16383. A finished result sits in an output
// register, so the next item is accepted while it waits; the result load stalls only while
// the previous result has not been taken.

module fat_chain_manager #(
	parameter int MAX_ENTRIES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	fcm_req_if.sink             request,
	fcm_rsp_if.source           response,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import fcm_pkg::*;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [CNT_W-1:0] dbc;

	fcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dbc     (dbc)
	);

	fcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	fcm_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.dbc      (dbc),
		.request  (request),
		.response (response)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import fcm_pkg::*;

	localparam int FAT_DEPTH = 8192;
	localparam int IDLE_LIMIT = 300000;
	localparam logic [2:0] REG_DBC = 3'd0;

	typedef struct {
		op_t               op;
		logic [VAL_W-1:0]  blk;
		logic [CNT_W-1:0]  tally;
		st_t               st;
	} fat_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fcm_req_if req_ch ();
	fcm_rsp_if rsp_ch ();

	fat_chain_manager #(
		.MAX_ENTRIES(FAT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.response(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [VAL_W-1:0] fat_tbl [0:FAT_DEPTH-1];
	logic [CNT_W-1:0] blk_count;
	fat_result_t pending_results[$];
	logic [VAL_W-1:0] chain_pool[$];
	int mismatches;
	int idle_cycles = 0;
	bit no_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	function automatic int unsigned first_free(input int unsigned n);
		int unsigned i;
		for (i = 1; i < n; i++)
			if (fat_tbl[i] == 16'd0)
				return i;
		return 0;
	endfunction

	// table update and expected result for one item
	function automatic fat_result_t fat_apply(input op_t op, input logic [VAL_W-1:0] blk,
		input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] steps);
		fat_result_t r;
		int unsigned n;
		int unsigned cur;
		int unsigned i;
		int unsigned slot;
		logic [VAL_W-1:0] nxt;
		r.op = op;
		r.blk = '0;
		r.tally = '0;
		r.st = ST_OK;
		n = (blk_count > FAT_DEPTH) ? FAT_DEPTH : blk_count;
		case (op)
			OP_WRITE: begin
				if (blk < n) begin
					fat_tbl[blk] = val;
					r.blk = blk;
				end else
					r.st = ST_RANGE;
			end
			OP_READ: begin
				if (blk < n)
					r.blk = fat_tbl[blk];
				else
					r.st = ST_RANGE;
			end
			OP_ALLOC: begin
				slot = first_free(n);
				if (slot != 0) begin
					fat_tbl[slot] = END_MARK;
					r.blk = slot[VAL_W-1:0];
				end else
					r.st = ST_FULL;
			end
			OP_APPEND: begin
				if (blk >= n)
					r.st = ST_RANGE;
				else begin
					slot = first_free(n);
					if (slot != 0) begin
						fat_tbl[blk] = slot[VAL_W-1:0];
						fat_tbl[slot] = END_MARK;
						r.blk = slot[VAL_W-1:0];
					end else
						r.st = ST_FULL;
				end
			end
			OP_SEEK: begin
				cur = blk;
				for (i = 0; i < steps; i++) begin
					if (cur >= n) begin
						r.st = ST_RANGE;
						break;
					end
					if (fat_tbl[cur] == END_MARK) begin
						r.st = ST_EARLY;
						break;
					end
					cur = fat_tbl[cur];
				end
				r.blk = cur[VAL_W-1:0];
			end
			OP_FREE: begin
				cur = blk;
				for (i = 0; cur != END_MARK; i++) begin
					if (cur == 0 || cur >= n) begin
						r.st = ST_RANGE;
						break;
					end
					if (i >= n) begin
						r.st = ST_EARLY;
						break;
					end
					nxt = fat_tbl[cur];
					fat_tbl[cur] = '0;
					r.tally = r.tally + 1'b1;
					cur = nxt;
				end
			end
			OP_COUNT: begin
				for (i = 1; i < n; i++)
					if (fat_tbl[i] == 16'd0)
						r.tally = r.tally + 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input op_t op, input logic [VAL_W-1:0] blk,
		input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] steps, output fat_result_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.block <= blk;
		req_ch.entry_value <= val;
		req_ch.hops <= steps;
		do @(posedge clk); while (!req_ch.ready);
		r = fat_apply(op, blk, val, steps);
		pending_results.push_back(r);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [31:0] data, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_DBC;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_block_count(input logic [CNT_W-1:0] v);
		logic [31:0] rd;
		wait_idle();
		apb_xfer(1'b1, {18'd0, v}, rd);
		blk_count = v;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd[CNT_W-1:0] !== v)
			note_mismatch($sformatf("data_block_count readback: expected %0d got %0d",
				v, rd[CNT_W-1:0]));
	endtask

	task automatic test_reset_state();
		fat_result_t r;
		send_item(OP_READ, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_READ, 16'd8191, 16'd0, 16'd0, r);
		send_item(OP_READ, 16'd8192, 16'd0, 16'd0, r);
		send_item(OP_COUNT, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_ALLOC, 16'd0, 16'd0, 16'd0, r);
	endtask

	task automatic test_chain_ops();
		fat_result_t r;
		set_block_count(14'd4);
		send_item(OP_APPEND, 16'd1, 16'd0, 16'd0, r);
		// block 3 is itself the free entry found
		send_item(OP_APPEND, 16'd3, 16'd0, 16'd0, r);
		send_item(OP_ALLOC, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_APPEND, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_SEEK, 16'd1, 16'd0, 16'd5, r);
		send_item(OP_SEEK, 16'd1, 16'd0, 16'd0, r);
		send_item(OP_WRITE, 16'd3, 16'd9, 16'd0, r);
		send_item(OP_SEEK, 16'd3, 16'd0, 16'd2, r);
		send_item(OP_FREE, 16'd3, 16'd0, 16'd0, r);
		send_item(OP_FREE, 16'd1, 16'd0, 16'd0, r);
	endtask

	task automatic test_field_limits();
		fat_result_t r;
		send_item(OP_FREE, 16'hFFFF, 16'd0, 16'd0, r);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_WRITE, 16'hFFFF, 16'hFFFF, 16'd0, r);
		send_item(OP_SEEK, 16'hFFFF, 16'd0, 16'hFFFF, r);
		send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, r);
		// self loop, walked for the full hop count
		send_item(OP_WRITE, 16'd2, 16'd2, 16'd0, r);
		send_item(OP_SEEK, 16'd2, 16'd0, 16'hFFFF, r);
		send_item(OP_COUNT, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_ALLOC, 16'd0, 16'd0, 16'd0, r);
		send_item(OP_FREE, 16'd2, 16'd0, 16'd0, r);
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] count_val, input int items);
		fat_result_t r;
		int k;
		int pick;
		int unsigned lim;
		op_t op;
		logic [VAL_W-1:0] blk;
		logic [VAL_W-1:0] val;
		logic [VAL_W-1:0] steps;
		set_block_count(count_val);
		lim = (count_val > FAT_DEPTH) ? FAT_DEPTH : count_val;
		for (k = 0; k < items; k++) begin
			if (k % 40 == 0)
				no_gaps = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				op = OP_ALLOC;
			else if (pick < 40)
				op = OP_APPEND;
			else if (pick < 55)
				op = OP_SEEK;
			else if (pick < 65)
				op = OP_FREE;
			else if (pick < 76)
				op = OP_READ;
			else if (pick < 88)
				op = OP_WRITE;
			else if (pick < 97)
				op = OP_COUNT;
			else
				op = OP_NONE;
			// full scans are slow on a large table
			if (op == OP_COUNT && lim > 1024 && $urandom_range(0, 3) != 0)
				op = OP_SEEK;
			pick = $urandom_range(0, 99);
			if (pick < 55 && chain_pool.size() != 0)
				blk = chain_pool[$urandom_range(0, chain_pool.size() - 1)];
			else if (pick < 85)
				blk = VAL_W'($urandom_range(0, lim + 1));
			else if (pick < 90)
				blk = END_MARK;
			else
				blk = VAL_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				val = '0;
			else if (pick < 45)
				val = END_MARK;
			else if (pick < 85)
				val = VAL_W'($urandom_range(0, lim + 1));
			else
				val = VAL_W'($urandom);
			steps = ($urandom_range(0, 127) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 12));
			send_item(op, blk, val, steps, r);
			if ((op == OP_ALLOC || op == OP_APPEND) && r.st == ST_OK) begin
				chain_pool.push_back(r.blk);
				if (chain_pool.size() > 16)
					void'(chain_pool.pop_front());
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		int unsigned i;
		for (i = 0; i < FAT_DEPTH; i++)
			fat_tbl[i] = '0;
		fat_tbl[0] = END_MARK;
		blk_count = DBC_RESET;
		mismatches = 0;
		no_gaps = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= '0;
		req_ch.block <= '0;
		req_ch.entry_value <= '0;
		req_ch.hops <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_chain_ops();
		test_field_limits();
		random_phase(14'd16, 300);
		random_phase(14'd2, 60);
		random_phase(14'd0, 30);
		random_phase(14'd1, 30);
		random_phase(14'd64, 400);
		random_phase(14'd16383, 80);
		random_phase(14'd8192, 80);
		random_phase(14'd3, 100);
		random_phase(14'd200, 400);
		random_phase(14'd17, 370);
		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		fat_result_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0)
				note_mismatch($sformatf("unexpected item: block %h tally %0d status %0d",
					rsp_ch.result_block, rsp_ch.tally, rsp_ch.status));
			else begin
				e = pending_results.pop_front();
				if (rsp_ch.result_block !== e.blk || rsp_ch.tally !== e.tally ||
					rsp_ch.status !== e.st)
					note_mismatch($sformatf(
						"op %s: expected block %h tally %0d status %0d, got block %h tally %0d status %0d",
						e.op.name(), e.blk, e.tally, e.st, rsp_ch.result_block, rsp_ch.tally,
						rsp_ch.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
